[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/ctg_pkg.sv]
// Shared types, widths and constants of the circular trajectory generator.
// No dependencies.
package ctg_pkg;

    localparam int CORDIC_STEPS_DEF = 18;

    // Register and field widths
    localparam int D_W       = 32;
    localparam int RATE_W    = 20;
    localparam int HD_W      = 19;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 3'd4;

    // Phase product and modulo reduction
    localparam int PROD_W    = 52;
    localparam int MAG_W     = 52;
    localparam int MOD_STEPS = 24;
    localparam int TP_W      = 29;
    localparam logic [TP_W-1:0] TWO_PI_Q26 = 29'd421657428;

    // Angles in Q.30
    localparam int RZ_W = 34;
    localparam logic signed [RZ_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [RZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [RZ_W-1:0] TWO_PI_Q30  = 34'sd6746518848;

    // Rotation CORDIC
    localparam int RX_W = 33;
    localparam logic signed [RX_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam int CS_W = 18;

    // Vectoring CORDIC
    localparam int V_W = 59;
    localparam logic signed [HD_W-1:0] HEADING_MAX = 19'sd205887;

    // Scaled radius products
    localparam int RW_W  = 36;
    localparam int RWW_W = 40;

    // Truncated arctangents of 2^-i in Q.30
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // Pipeline control handed to each section
    typedef struct packed {
        logic en;
        logic vld;
    } t_stg_ctl;

    // Saturate to the signed 32-bit range
    function automatic logic signed [D_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [D_W-1:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[D_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/ctg_sincos.sv]
// Phase reduction modulo 2*pi and rotation-mode CORDIC giving Q16 sine/cosine.
// Depends on ctg_pkg. A side word rides along with each item.
module ctg_sincos #(
    parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W       = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ctg_pkg::t_stg_ctl                   i_ctl,
    input  logic signed [ctg_pkg::PROD_W-1:0]   i_prod,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_vld,
    output logic signed [ctg_pkg::CS_W-1:0]     o_sin,
    output logic signed [ctg_pkg::CS_W-1:0]     o_cos,
    output logic [SIDE_W-1:0]                   o_side
);
    import ctg_pkg::*;

    localparam int LAT = MOD_STEPS + CORDIC_STEPS + 5;
    localparam logic signed [RX_W-1:0] RND14 = 33'sd8192;

    logic                      r_vld  [LAT];
    logic [SIDE_W-1:0]         r_side [LAT];
    logic [MAG_W-1:0]          r_rem  [MOD_STEPS+1];
    logic                      r_pneg [MOD_STEPS+1];
    logic [TP_W-1:0]           r_ph;
    logic signed [RZ_W-1:0]    r_zw;
    logic signed [RX_W-1:0]    r_x    [CORDIC_STEPS+1];
    logic signed [RX_W-1:0]    r_y    [CORDIC_STEPS+1];
    logic signed [RZ_W-1:0]    r_z    [CORDIC_STEPS+1];
    logic                      r_flip [CORDIC_STEPS+1];
    logic signed [CS_W-1:0]    r_sin;
    logic signed [CS_W-1:0]    r_cos;

    logic signed [RZ_W-1:0]    n_zu;
    logic signed [RX_W-1:0]    n_xr;
    logic signed [RX_W-1:0]    n_yr;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_vld[s] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int s = 1; s < LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Side word travels with the item
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < LAT; s++) r_side[s] <= r_side[s-1];
        end
    end

    // Magnitude and sign of the phase product
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pneg[0] <= i_prod[PROD_W-1];
            r_rem[0]  <= i_prod[PROD_W-1] ? $unsigned(-i_prod) : $unsigned(i_prod);
        end
    end

    // Restoring reduction, one power-of-two multiple of 2*pi per stage
    for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
        localparam logic [MAG_W-1:0] SUB = MAG_W'(TWO_PI_Q26) << (MOD_STEPS - 1 - j);
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_pneg[j+1] <= r_pneg[j];
                r_rem[j+1]  <= (r_rem[j] >= SUB) ? r_rem[j] - SUB : r_rem[j];
            end
        end
    end

    // Negative phase maps to 2*pi minus the remainder
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (r_pneg[MOD_STEPS] && (r_rem[MOD_STEPS] != '0)) begin
                r_ph <= TWO_PI_Q26 - r_rem[MOD_STEPS][TP_W-1:0];
            end else begin
                r_ph <= r_rem[MOD_STEPS][TP_W-1:0];
            end
        end
    end

    // Scale to Q.30 and wrap into (-pi, pi]
    assign n_zu = $signed({1'b0, r_ph, 4'b0000});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_zw <= (n_zu > PI_Q30) ? n_zu - TWO_PI_Q30 : n_zu;
        end
    end

    // Fold into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            if (r_zw > HALF_PI_Q30) begin
                r_z[0]    <= r_zw - PI_Q30;
                r_flip[0] <= 1'b1;
            end else if (r_zw < -HALF_PI_Q30) begin
                r_z[0]    <= r_zw + PI_Q30;
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= r_zw;
                r_flip[0] <= 1'b0;
            end
        end
    end

    // Rotation steps
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [RZ_W-1:0] ANG = RZ_W'(ATAN_Q30[i]);
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (!r_z[i][RZ_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    // Undo the fold and round to Q16
    assign n_xr = (r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS]) + RND14;
    assign n_yr = (r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS]) + RND14;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_cos <= n_xr[CS_W+13:14];
            r_sin <= n_yr[CS_W+13:14];
        end
    end

    assign o_vld  = r_vld[LAT-1];
    assign o_side = r_side[LAT-1];
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

[rtl/core/ctg_atan2.sv]
// Vectoring-mode CORDIC giving the clamped Q16 heading of a velocity vector.
// Depends on ctg_pkg. A side word rides along with each item.
module ctg_atan2 #(
    parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W       = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ctg_pkg::t_stg_ctl                 i_ctl,
    input  logic signed [ctg_pkg::D_W-1:0]    i_vx,
    input  logic signed [ctg_pkg::D_W-1:0]    i_vy,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_vld,
    output logic signed [ctg_pkg::HD_W-1:0]   o_heading,
    output logic [SIDE_W-1:0]                 o_side
);
    import ctg_pkg::*;

    localparam int LAT = CORDIC_STEPS + 2;
    localparam logic signed [RZ_W-1:0] RND14 = 34'sd8192;
    localparam logic signed [RZ_W-1:0] H_MAX = RZ_W'(HEADING_MAX);

    logic                    r_vld  [LAT];
    logic [SIDE_W-1:0]       r_side [LAT];
    logic signed [V_W-1:0]   r_x    [CORDIC_STEPS+1];
    logic signed [V_W-1:0]   r_y    [CORDIC_STEPS+1];
    logic signed [RZ_W-1:0]  r_z    [CORDIC_STEPS+1];
    logic signed [RZ_W-1:0]  r_off  [CORDIC_STEPS+1];
    logic                    r_zero [CORDIC_STEPS+1];
    logic signed [HD_W-1:0]  r_head;

    logic                    n_neg;
    logic signed [D_W:0]     n_xe;
    logic signed [D_W:0]     n_ye;
    logic signed [RZ_W-1:0]  n_hs;
    logic signed [RZ_W-1:0]  n_h;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_vld[s] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int s = 1; s < LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Side word
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < LAT; s++) r_side[s] <= r_side[s-1];
        end
    end

    // Left half plane: mirror the vector and add +/- pi at the end
    assign n_neg = i_vx[D_W-1];
    assign n_xe  = n_neg ? -(D_W+1)'(i_vx) : (D_W+1)'(i_vx);
    assign n_ye  = n_neg ? -(D_W+1)'(i_vy) : (D_W+1)'(i_vy);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0]    <= V_W'(n_xe) <<< 24;
            r_y[0]    <= V_W'(n_ye) <<< 24;
            r_z[0]    <= '0;
            r_off[0]  <= !n_neg ? '0 : (!i_vy[D_W-1] ? PI_Q30 : -PI_Q30);
            r_zero[0] <= (i_vx == '0) && (i_vy == '0);
        end
    end

    // Vectoring steps drive y towards zero
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        localparam logic signed [RZ_W-1:0] ANG = RZ_W'(ATAN_Q30[i]);
        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (r_y[i][V_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end
                r_off[i+1]  <= r_off[i];
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // Add offset, round to Q16, clamp; a zero vector gives zero
    assign n_hs = r_z[CORDIC_STEPS] + r_off[CORDIC_STEPS] + RND14;
    assign n_h  = n_hs >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (r_zero[CORDIC_STEPS]) begin
                r_head <= '0;
            end else if (n_h > H_MAX) begin
                r_head <= HEADING_MAX;
            end else if (n_h < -H_MAX) begin
                r_head <= -HEADING_MAX;
            end else begin
                r_head <= n_h[HD_W-1:0];
            end
        end
    end

    assign o_vld     = r_vld[LAT-1];
    assign o_side    = r_side[LAT-1];
    assign o_heading = r_head;

endmodule

[rtl/core/circular_trajectory_generator_core.sv]
// Circular trajectory generator: position, velocity, acceleration and heading per time sample.
// Pipelined through the front products, the phase reduction stages and the two CORDIC
// pipelines; one transfer is accepted per cycle while the output does not stall.
// A stall at the output freezes the whole pipeline. Synchronous active-low reset clears
// all valid bits and loads the register defaults. Depends on ctg_pkg, ctg_sincos, ctg_atan2, assert_macros.svh.
`include "assert_macros.svh"
module circular_trajectory_generator_core #(
    parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ctg_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ctg_pkg::D_W-1:0]               i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ctg_pkg::D_W-1:0]               i_elapsed_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ctg_pkg::D_W-1:0]        o_pos_x,
    output logic signed [ctg_pkg::D_W-1:0]        o_pos_y,
    output logic signed [ctg_pkg::D_W-1:0]        o_pos_z,
    output logic signed [ctg_pkg::D_W-1:0]        o_vel_x,
    output logic signed [ctg_pkg::D_W-1:0]        o_vel_y,
    output logic signed [ctg_pkg::D_W-1:0]        o_acc_x,
    output logic signed [ctg_pkg::D_W-1:0]        o_acc_y,
    output logic signed [ctg_pkg::HD_W-1:0]       o_heading,
    output logic signed [ctg_pkg::RATE_W-1:0]     o_heading_rate
);
    import ctg_pkg::*;

    localparam int SC_SIDE_W = RW_W + RWW_W;
    localparam int AT_SIDE_W = 6 * D_W;

    // Configuration registers
    logic signed [D_W-1:0]    r_radius;
    logic signed [RATE_W-1:0] r_rate;
    logic signed [D_W-1:0]    r_cx;
    logic signed [D_W-1:0]    r_cy;
    logic signed [D_W-1:0]    r_cz;

    // Front stages
    logic                        r_vld_t0, r_vld_t1, r_vld_t2;
    logic signed [PROD_W-1:0]    r_prod, r_prod1, r_prod2;
    logic signed [PROD_W-1:0]    r_rwp;
    logic signed [RW_W-1:0]      r_rw, r_rw2;
    logic signed [RW_W+RATE_W-1:0] r_rwwp;

    // Product and output-forming stages
    logic                        r_vld_p, r_vld_q;
    logic signed [D_W+CS_W-1:0]  r_pcx, r_pcy;
    logic signed [RW_W+CS_W-1:0] r_pvx, r_pvy;
    logic signed [RWW_W+CS_W-1:0] r_pax, r_pay;
    logic signed [D_W-1:0]       r_posx, r_posy, r_vx, r_vy, r_ax, r_ay;

    logic                        adv;
    logic signed [63:0]          n_rw64;
    logic signed [63:0]          n_rww64;
    t_stg_ctl                    sc_ctl, at_ctl;
    logic                        sc_vld;
    logic signed [CS_W-1:0]      sc_sin, sc_cos;
    logic [SC_SIDE_W-1:0]        sc_side_in, sc_side;
    logic signed [RW_W-1:0]      sc_rw;
    logic signed [RWW_W-1:0]     sc_rww;
    logic [AT_SIDE_W-1:0]        at_side_in, at_side;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 32'sd327680;
            r_rate   <= 20'sd32768;
            r_cx     <= -32'sd1179648;
            r_cy     <= -32'sd65536;
            r_cz     <= 32'sd131072;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:   r_radius <= i_cfg_data;
                CFG_RATE:     r_rate   <= i_cfg_data[RATE_W-1:0];
                CFG_CENTRE_X: r_cx     <= i_cfg_data;
                CFG_CENTRE_Y: r_cy     <= i_cfg_data;
                CFG_CENTRE_Z: r_cz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves unless the output holds an untaken transfer
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // Valid bits of the front and product stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_t0 <= 1'b0;
            r_vld_t1 <= 1'b0;
            r_vld_t2 <= 1'b0;
            r_vld_p  <= 1'b0;
            r_vld_q  <= 1'b0;
        end else if (adv) begin
            r_vld_t0 <= i_in_valid;
            r_vld_t1 <= r_vld_t0;
            r_vld_t2 <= r_vld_t1;
            r_vld_p  <= sc_vld;
            r_vld_q  <= r_vld_p;
        end
    end

    // Phase product w*t and scaled radius r*w, then r*w*w
    assign n_rw64  = (64'(r_rwp) + 64'sd32768) >>> 16;
    assign n_rww64 = (64'(r_rwwp) + 64'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod  <= $signed({1'b0, i_elapsed_time}) * r_rate;
            r_rwp   <= r_radius * r_rate;
            r_prod1 <= r_prod;
            r_rw    <= n_rw64[RW_W-1:0];
            r_prod2 <= r_prod1;
            r_rw2   <= r_rw;
            r_rwwp  <= r_rw * r_rate;
        end
    end

    // Sine and cosine of the reduced phase
    assign sc_ctl     = '{en: adv, vld: r_vld_t2};
    assign sc_side_in = {r_rw2, n_rww64[RWW_W-1:0]};

    ctg_sincos #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SIDE_W       (SC_SIDE_W)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sc_ctl),
        .i_prod  (r_prod2),
        .i_side  (sc_side_in),
        .o_vld   (sc_vld),
        .o_sin   (sc_sin),
        .o_cos   (sc_cos),
        .o_side  (sc_side)
    );

    assign sc_rw  = sc_side[SC_SIDE_W-1:RWW_W];
    assign sc_rww = sc_side[RWW_W-1:0];

    // Products with sine and cosine
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pcx <= r_radius * sc_cos;
            r_pcy <= r_radius * sc_sin;
            r_pvx <= sc_rw * sc_sin;
            r_pvy <= sc_rw * sc_cos;
            r_pax <= sc_rww * sc_cos;
            r_pay <= sc_rww * sc_sin;
        end
    end

    // Round, negate where needed, add centre, saturate
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_posx <= sat32(64'(r_cx) + ((64'(r_pcx) + 64'sd32768) >>> 16));
            r_posy <= sat32(64'(r_cy) + ((64'(r_pcy) + 64'sd32768) >>> 16));
            r_vx   <= sat32((64'sd32768 - 64'(r_pvx)) >>> 16);
            r_vy   <= sat32((64'(r_pvy) + 64'sd32768) >>> 16);
            r_ax   <= sat32((64'sd32768 - 64'(r_pax)) >>> 16);
            r_ay   <= sat32((64'sd32768 - 64'(r_pay)) >>> 16);
        end
    end

    // Heading of the velocity vector
    assign at_ctl     = '{en: adv, vld: r_vld_q};
    assign at_side_in = {r_posx, r_posy, r_vx, r_vy, r_ax, r_ay};

    ctg_atan2 #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SIDE_W       (AT_SIDE_W)
    ) u_atan2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (at_ctl),
        .i_vx      (r_vx),
        .i_vy      (r_vy),
        .i_side    (at_side_in),
        .o_vld     (o_out_valid),
        .o_heading (o_heading),
        .o_side    (at_side)
    );

    // Result fields
    assign o_pos_x        = at_side[6*D_W-1:5*D_W];
    assign o_pos_y        = at_side[5*D_W-1:4*D_W];
    assign o_vel_x        = at_side[4*D_W-1:3*D_W];
    assign o_vel_y        = at_side[3*D_W-1:2*D_W];
    assign o_acc_x        = at_side[2*D_W-1:D_W];
    assign o_acc_y        = at_side[D_W-1:0];
    assign o_pos_z        = r_cz;
    assign o_heading_rate = r_rate;

    // Heading must line up with the velocity it came from
    `ASSERT_IMPLY(a_zero_vec_heading, i_clk, i_rst_n, o_out_valid && o_vel_x == 32'sd0 && o_vel_y == 32'sd0, o_heading == 19'sd0)
    `ASSERT_IMPLY(a_right_half_heading, i_clk, i_rst_n, o_out_valid && !o_vel_x[31] && o_vel_x != 32'sd0, o_heading <= 19'sd115000 && o_heading >= -19'sd115000)

endmodule
